### sv/mtep_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the track event parser.
package mtep_pkg;

    localparam int QUANTITY_MAX_BYTES_DEF = 4;
    localparam int TIME_WIDTH_DEF         = 48;
    localparam logic [23:0] DEFAULT_TEMPO_RESET = 24'd500000;

    // parse phases
    localparam logic [2:0] PH_DELTA    = 3'd0;
    localparam logic [2:0] PH_STATUS   = 3'd1;
    localparam logic [2:0] PH_CHDATA   = 3'd2;
    localparam logic [2:0] PH_METATYPE = 3'd3;
    localparam logic [2:0] PH_LENGTH   = 3'd4;
    localparam logic [2:0] PH_PAYLOAD  = 3'd5;

    // byte roles
    localparam logic [2:0] ROLE_DELTA    = 3'd0;
    localparam logic [2:0] ROLE_STATUS   = 3'd1;
    localparam logic [2:0] ROLE_CHDATA   = 3'd2;
    localparam logic [2:0] ROLE_METATYPE = 3'd3;
    localparam logic [2:0] ROLE_LENGTH   = 3'd4;
    localparam logic [2:0] ROLE_PAYLOAD  = 3'd5;

    // event classes
    localparam logic [1:0] CLS_VOICE = 2'd0;
    localparam logic [1:0] CLS_MODE  = 2'd1;
    localparam logic [1:0] CLS_SYSEX = 2'd2;
    localparam logic [1:0] CLS_META  = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_QTY_LONG = 2'd1;
    localparam logic [1:0] ERR_BAD_STAT = 2'd2;
    localparam logic [1:0] ERR_TRUNC    = 2'd3;

    localparam logic [7:0] ST_VOICE_MAX    = 8'hEF;
    localparam logic [7:0] ST_SYSEX        = 8'hF0;
    localparam logic [7:0] ST_ESCAPE       = 8'hF7;
    localparam logic [7:0] ST_META         = 8'hFF;
    localparam logic [7:0] META_SET_TEMPO  = 8'h51;
    localparam logic [7:0] CTRL_MODE_FIRST = 8'h78;
    localparam logic [3:0] NIB_CONTROL     = 4'hB;
    localparam logic [3:0] NIB_PROGRAM     = 4'hC;
    localparam logic [3:0] NIB_PRESSURE    = 4'hD;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       track_start;
        logic       chunk_last;
    } mtep_item_t;

    typedef struct packed {
        logic [2:0]  byte_role;
        logic [1:0]  event_class;
        logic [7:0]  status_value;
        logic [3:0]  channel_number;
        logic [7:0]  meta_kind;
        logic [27:0] payload_length;
        logic [47:0] absolute_time;
        logic [23:0] tempo_now;
        logic        event_end;
        logic [1:0]  error_code;
    } mtep_result_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  running_status;
        logic [27:0] qty_acc;
        logic [1:0]  qty_bytes;
        logic [27:0] remaining;
        logic [23:0] tempo;
        logic [7:0]  current_meta;
        logic [7:0]  first_data;
        logic [27:0] event_length;
    } mtep_state_t;

    function automatic logic [1:0] data_count(input logic [7:0] st);
        logic [1:0] n;
        n = (st[7:4] == NIB_PROGRAM || st[7:4] == NIB_PRESSURE) ? 2'd1 : 2'd2;
        return n;
    endfunction

    function automatic logic [1:0] class_of(input logic [7:0] st, input logic [7:0] fd);
        logic [1:0] c;
        if (st >= ST_SYSEX)
            c = (st == ST_META) ? CLS_META : CLS_SYSEX;
        else if (st[7:4] == NIB_CONTROL && fd >= CTRL_MODE_FIRST)
            c = CLS_MODE;
        else
            c = CLS_VOICE;
        return c;
    endfunction

endpackage

### sv/mtep_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input bytes, results and the tempo register write.
interface mtep_item_if
    import mtep_pkg::*;
();
    logic       valid;
    logic       ready;
    mtep_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mtep_result_if
    import mtep_pkg::*;
();
    logic         valid;
    logic         ready;
    mtep_result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mtep_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] default_tempo;

    modport source (output valid, output default_tempo, input ready);
    modport sink   (input valid, input default_tempo, output ready);
endinterface

### sv/mtep_decode.sv
`timescale 1ns / 1ps
// Single-byte parse step: next parser state and the result for one item.
module mtep_decode
    import mtep_pkg::*;
#(
    parameter int QUANTITY_MAX_BYTES = QUANTITY_MAX_BYTES_DEF,
    parameter int TIME_WIDTH         = TIME_WIDTH_DEF
)
(
    input  mtep_item_t              item,
    input  mtep_state_t             state,
    input  logic [TIME_WIDTH-1:0]   time_total,
    input  logic [23:0]             default_tempo,
    output mtep_state_t             state_next,
    output logic [TIME_WIDTH-1:0]   time_next,
    output mtep_result_t            result
);

    function automatic mtep_state_t resync(input mtep_state_t x);
        mtep_state_t y;
        y           = x;
        y.phase     = PH_DELTA;
        y.qty_acc   = '0;
        y.qty_bytes = '0;
        y.remaining = '0;
        return y;
    endfunction

    mtep_state_t             s;
    logic [TIME_WIDTH-1:0]   t;
    logic [TIME_WIDTH:0]     t_sum;
    logic [TIME_WIDTH+47:0]  t_ext;
    logic [7:0]              b;
    logic [27:0]             qx;
    logic [2:0]              qb_inc;
    logic                    ovf;
    logic [27:0]             consumed;
    logic [2:0]              role;
    logic [1:0]              cls;
    logic [7:0]              st;
    logic [3:0]              ch;
    logic [7:0]              mk;
    logic [27:0]             plen;
    logic                    end_f;
    logic [1:0]              err;

    always_comb
    begin
        b = item.body_byte;
        if (item.track_start)
        begin
            s.phase          = PH_DELTA;
            s.running_status = '0;
            s.qty_acc        = '0;
            s.qty_bytes      = '0;
            s.remaining      = '0;
            s.tempo          = default_tempo;
            s.current_meta   = '0;
            s.first_data     = '0;
            s.event_length   = '0;
            t                = '0;
        end
        else
        begin
            s = state;
            t = time_total;
        end

        qx       = {s.qty_acc[20:0], b[6:0]};
        qb_inc   = {1'b0, s.qty_bytes} + 3'd1;
        ovf      = b[7] && (qb_inc >= 3'(QUANTITY_MAX_BYTES));
        consumed = s.event_length - s.remaining;
        t_sum    = {1'b0, t} + (TIME_WIDTH + 1)'(qx);

        role  = ROLE_DELTA;
        cls   = CLS_VOICE;
        st    = '0;
        ch    = '0;
        mk    = '0;
        plen  = '0;
        end_f = 1'b0;
        err   = ERR_NONE;

        case (s.phase)
            PH_STATUS:
            begin
                role = ROLE_STATUS;
                if (b[7])
                begin
                    st = b;
                    if (b <= ST_VOICE_MAX)
                    begin
                        s.running_status = b;
                        s.first_data     = '0;
                        s.remaining      = 28'(data_count(b));
                        s.phase          = PH_CHDATA;
                        ch               = b[3:0];
                        cls              = CLS_VOICE;
                    end
                    else if (b == ST_SYSEX || b == ST_ESCAPE)
                    begin
                        s.running_status = b;
                        s.current_meta   = '0;
                        s.qty_acc        = '0;
                        s.qty_bytes      = '0;
                        s.phase          = PH_LENGTH;
                        cls              = CLS_SYSEX;
                    end
                    else if (b == ST_META)
                    begin
                        s.running_status = b;
                        s.current_meta   = '0;
                        s.phase          = PH_METATYPE;
                        cls              = CLS_META;
                    end
                    else
                    begin
                        err = ERR_BAD_STAT;
                        s   = resync(s);
                    end
                end
                else if (s.running_status[7] && s.running_status <= ST_VOICE_MAX)
                begin
                    // running status: this byte is the first data byte
                    role         = ROLE_CHDATA;
                    st           = s.running_status;
                    ch           = st[3:0];
                    s.first_data = b;
                    cls          = class_of(st, b);
                    if (data_count(st) == 2'd1)
                    begin
                        end_f = 1'b1;
                        s     = resync(s);
                    end
                    else
                    begin
                        s.remaining = 28'd1;
                        s.phase     = PH_CHDATA;
                    end
                end
                else
                begin
                    err = ERR_BAD_STAT;
                    s   = resync(s);
                end
            end
            PH_CHDATA:
            begin
                role = ROLE_CHDATA;
                st   = s.running_status;
                ch   = st[3:0];
                if (s.remaining >= 28'd2)
                    s.first_data = b;
                cls = class_of(st, s.first_data);
                if (s.remaining <= 28'd1)
                begin
                    end_f = 1'b1;
                    s     = resync(s);
                end
                else
                    s.remaining = s.remaining - 28'd1;
            end
            PH_METATYPE:
            begin
                role           = ROLE_METATYPE;
                st             = ST_META;
                cls            = CLS_META;
                s.current_meta = b;
                mk             = b;
                s.qty_acc      = '0;
                s.qty_bytes    = '0;
                s.phase        = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                role      = ROLE_LENGTH;
                st        = s.running_status;
                cls       = class_of(st, s.first_data);
                mk        = s.current_meta;
                s.qty_acc = qx;
                if (b[7])
                begin
                    if (ovf)
                    begin
                        err = ERR_QTY_LONG;
                        s   = resync(s);
                    end
                    else
                        s.qty_bytes = qb_inc[1:0];
                end
                else
                begin
                    s.qty_bytes    = '0;
                    s.event_length = qx;
                    plen           = qx;
                    s.qty_acc      = '0;
                    if (qx == '0)
                    begin
                        end_f = 1'b1;
                        s     = resync(s);
                    end
                    else
                    begin
                        s.remaining = qx;
                        s.phase     = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                role = ROLE_PAYLOAD;
                st   = s.running_status;
                cls  = class_of(st, s.first_data);
                mk   = s.current_meta;
                plen = s.event_length;
                // first three payload bytes shift in as a big-endian tempo
                if (consumed < 28'd3)
                    s.qty_acc = {4'b0, s.qty_acc[15:0], b};
                if (s.remaining <= 28'd1)
                begin
                    end_f = 1'b1;
                    if (s.running_status == ST_META && s.current_meta == META_SET_TEMPO
                        && s.event_length >= 28'd3)
                        s.tempo = s.qty_acc[23:0];
                    s = resync(s);
                end
                else
                    s.remaining = s.remaining - 28'd1;
            end
            default:
            begin
                role      = ROLE_DELTA;
                s.qty_acc = qx;
                if (b[7])
                begin
                    if (ovf)
                    begin
                        err = ERR_QTY_LONG;
                        s   = resync(s);
                    end
                    else
                    begin
                        s.qty_bytes = qb_inc[1:0];
                        s.phase     = PH_DELTA;
                    end
                end
                else
                begin
                    s.qty_bytes = '0;
                    t           = t_sum[TIME_WIDTH] ? '1 : t_sum[TIME_WIDTH-1:0];
                    s.qty_acc   = '0;
                    s.phase     = PH_STATUS;
                end
            end
        endcase

        if (item.chunk_last)
        begin
            if (err == ERR_NONE && !(s.phase == PH_DELTA && s.qty_bytes == '0))
                err = ERR_TRUNC;
            s = resync(s);
        end

        t_ext = {48'b0, t};

        state_next = s;
        time_next  = t;

        result.byte_role      = role;
        result.event_class    = cls;
        result.status_value   = st;
        result.channel_number = ch;
        result.meta_kind      = mk;
        result.payload_length = plen;
        result.absolute_time  = t_ext[47:0];
        result.tempo_now      = s.tempo;
        result.event_end      = end_f;
        result.error_code     = err;
    end

endmodule

### sv/midi_track_event_parser_unit.sv
`timescale 1ns / 1ps
// Track chunk event parser: top level with input register, parser state and result register.
//
// byte_ch carries one track body byte per item with its track_start and chunk_last
// marks; result_ch gives exactly one result item per byte, in order.
// cfg writes the default tempo, loaded into the tempo at every track_start.
// Write it only while no byte is in flight.
// An accepted byte waits in the input register, is parsed from there and its result is
// held in the result register. Throughput is one byte per cycle while result_ch does not
// stall; the combinational parse step updates the parser state between bytes.
// When result_ch stalls, the result register holds its item and one more byte
// waits in the input register; byte_ch drops ready only once both are full.
// Reset empties both registers, sets the default tempo and the tempo to
// 500000 and puts the parser in wait for a delta time with no running status.
// cfg.ready is always high.
module midi_track_event_parser_unit
    import mtep_pkg::*;
#(
    parameter int QUANTITY_MAX_BYTES = QUANTITY_MAX_BYTES_DEF,
    parameter int TIME_WIDTH         = TIME_WIDTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    mtep_item_if.sink       byte_ch,
    mtep_result_if.source   result_ch,
    mtep_cfg_if.sink        cfg
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    mtep_item_t             item_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    mtep_result_t           result_reg;
    mtep_result_t           result_next;
    mtep_state_t            state_reg;
    mtep_state_t            state_next;
    logic [TIME_WIDTH-1:0]  time_reg;
    logic [TIME_WIDTH-1:0]  time_next;
    logic [23:0]            default_tempo_reg;
    logic                   advance;
    logic                   byte_accept;

    assign advance     = in_valid_reg && (!out_valid_reg || result_ch.ready);
    assign byte_ch.ready = !in_valid_reg || advance;
    assign byte_accept = byte_ch.valid && byte_ch.ready;
    assign cfg.ready   = 1'b1;

    assign in_valid_next  = byte_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 :
                            (result_ch.ready ? 1'b0 : out_valid_reg);

    assign result_ch.valid   = out_valid_reg;
    assign result_ch.payload = result_reg;

    mtep_decode #(
        .QUANTITY_MAX_BYTES (QUANTITY_MAX_BYTES),
        .TIME_WIDTH         (TIME_WIDTH)
    ) u_decode (
        .item          (item_reg),
        .state         (state_reg),
        .time_total    (time_reg),
        .default_tempo (default_tempo_reg),
        .state_next    (state_next),
        .time_next     (time_next),
        .result        (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
            default_tempo_reg        <= DEFAULT_TEMPO_RESET;
            state_reg.phase          <= PH_DELTA;
            state_reg.running_status <= '0;
            state_reg.qty_acc        <= '0;
            state_reg.qty_bytes      <= '0;
            state_reg.remaining      <= '0;
            state_reg.tempo          <= DEFAULT_TEMPO_RESET;
            state_reg.current_meta   <= '0;
            state_reg.first_data     <= '0;
            state_reg.event_length   <= '0;
            time_reg                 <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
                default_tempo_reg <= cfg.default_tempo;
            if (advance)
            begin
                state_reg <= state_next;
                time_reg  <= time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_accept)
            item_reg <= byte_ch.payload;
        if (advance)
            result_reg <= result_next;
    end

`ifndef NO_ASSERTIONS
    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_ch.valid)
        else $error("parsed item did not reach the result register");

    a_stalled_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("waiting input item lost");

    a_end_without_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && result_ch.payload.event_end
            |-> result_ch.payload.error_code == ERR_NONE)
        else $error("completed event carries an error");

    a_chdata_has_voice_status: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_CHDATA
            |-> state_reg.running_status[7] && state_reg.running_status <= ST_VOICE_MAX)
        else $error("channel data phase without a channel status");
`endif

endmodule
